// File: rtl/mjtm_pkg.sv
`timescale 1ns / 1ps
package mjtm_pkg;

  localparam int TAG_W      = 7;
  localparam int CHIP_W     = 8;
  localparam int INTERVAL_W = 9;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int PADDR_W    = 3;

  localparam logic [TAG_W-1:0]      TAG_STEP       = 7'd24;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 9'd128;
  localparam int                    VERSION_SHIFT  = 13;
  localparam int                    NONCE_CHIP_LSB = 17;

  // register table of a register response
  localparam logic [7:0] REG_ERR_COUNT = 8'h4C;
  localparam logic [7:0] REG_DOMAIN0   = 8'h88;
  localparam logic [7:0] REG_TOTAL     = 8'h8C;
  localparam logic [7:0] JOB_ID_MASK   = 8'hF0;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ISSUED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REG         = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NONCE       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN_REG = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STALE       = 3'd4;

  // register index of the chip spacing
  localparam logic REG_IDX_INTERVAL = 1'b0;

  typedef enum logic [1:0] {
    OP_ISSUE,
    OP_REG,
    OP_UNKNOWN,
    OP_NONCE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [TAG_W-1:0]  tag;
    logic [KIND_W-1:0] kind;
    logic [CHIP_W-1:0] addr;   // dividend of the chip index
    logic [31:0]       word;   // job version on issue, frame word otherwise
    logic [15:0]       fver;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag;
    logic [CHIP_W-1:0]   chip_index;
    logic [KIND_W-1:0]   register_kind;
    logic [31:0]         data_word;
    logic [31:0]         full_version;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } back_state_t;

endpackage

// File: rtl/mining_job_tag_result_matcher_core.sv
`timescale 1ns / 1ps
// job tag tracker and result frame matcher
//
// input channel (in_valid / in_ready): one beat is either a job issue
//   (action 0, job_version) or a decoded result frame (action 1 with the
//   frame fields). output channel (out_valid / out_ready): exactly one
//   result beat per input beat, in input order.
// configuration: APB write of the chip spacing at byte address 0,
//   pready tied high, reads return the current value.
// job issue, unknown register and stale job go straight to the result
//   register; register reads and nonce hits first run the chip index
//   through an 8-step restoring divider.
// the back end works one item at a time (store lookup then the shared
//   divider) and takes no new item while a result waits on out_ready.
// a two-entry command queue sits between the classifier and the back end,
//   so the input keeps taking beats until the queue is full.
// reset: next tag returns to zero, all job slots are marked invalid
//   at once, the spacing returns to 128; the version store is not
//   cleared since a slot is read only when its valid bit is set.
module mining_job_tag_result_matcher_core #(
  parameter int JOB_SLOTS = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  // item input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [31:0]                       job_version,
  input  logic                              nonce_resp,
  input  logic [31:0]                       frame_word,
  input  logic [7:0]                        frame_addr_byte,
  input  logic [7:0]                        frame_tag_byte,
  input  logic [15:0]                       frame_version,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mjtm_pkg::STATUS_W-1:0]     status,
  output logic [mjtm_pkg::TAG_W-1:0]        tag,
  output logic [mjtm_pkg::CHIP_W-1:0]       chip_index,
  output logic [mjtm_pkg::KIND_W-1:0]       register_kind,
  output logic [31:0]                       data_word,
  output logic [31:0]                       full_version,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mjtm_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [mjtm_pkg::INTERVAL_W-1:0] chip_spacing;

  logic           f_valid;
  logic           f_ready;
  mjtm_pkg::cmd_t f_cmd;
  logic           q_valid;
  logic           q_ready;
  mjtm_pkg::cmd_t q_cmd;
  mjtm_pkg::res_t res;

  // register index is the word address; the low byte-offset bits are ignored
  logic reg_hit;
  assign reg_hit = (paddr[mjtm_pkg::PADDR_W-1] == mjtm_pkg::REG_IDX_INTERVAL);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_spacing <= mjtm_pkg::INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      chip_spacing <= pwdata[mjtm_pkg::INTERVAL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = 32'(chip_spacing);
    end
  end

  // front end: tag assignment and frame classification
  mjtm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .job_version     (job_version),
    .nonce_resp      (nonce_resp),
    .frame_word      (frame_word),
    .frame_addr_byte (frame_addr_byte),
    .frame_tag_byte  (frame_tag_byte),
    .frame_version   (frame_version),
    .cmd_valid       (f_valid),
    .cmd_ready       (f_ready),
    .cmd             (f_cmd)
  );

  // decoupling queue
  mjtm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  // back end: job store, chip index divider, result register
  mjtm_back #(
    .JOB_SLOTS (JOB_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .interval  (chip_spacing),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign status         = res.status;
  assign tag            = res.tag;
  assign chip_index     = res.chip_index;
  assign register_kind  = res.register_kind;
  assign data_word      = res.data_word;
  assign full_version   = res.full_version;

endmodule

// File: rtl/mjtm_front.sv
`timescale 1ns / 1ps
module mjtm_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       action,
  input  logic [31:0]                job_version,
  input  logic                       nonce_resp,
  input  logic [31:0]                frame_word,
  input  logic [7:0]                 frame_addr_byte,
  input  logic [7:0]                 frame_tag_byte,
  input  logic [15:0]                frame_version,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output mjtm_pkg::cmd_t             cmd
);

  logic [mjtm_pkg::TAG_W-1:0] next_tag;
  logic [mjtm_pkg::TAG_W-1:0] issue_tag;

  assign issue_tag = next_tag + mjtm_pkg::TAG_STEP;
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_tag <= '0;
    end else if (in_valid && in_ready && !action) begin
      next_tag <= issue_tag;
    end
  end

  // classify the item
  always_comb begin
    cmd      = '0;
    cmd.fver = frame_version;
    if (!action) begin
      cmd.op   = mjtm_pkg::OP_ISSUE;
      cmd.tag  = issue_tag;
      cmd.word = job_version;
    end else if (nonce_resp) begin
      cmd.op   = mjtm_pkg::OP_NONCE;
      cmd.tag  = {frame_tag_byte[7:4] & mjtm_pkg::JOB_ID_MASK[7:4], 3'b000};
      cmd.addr = frame_word[mjtm_pkg::NONCE_CHIP_LSB +: mjtm_pkg::CHIP_W];
      cmd.word = frame_word;
    end else begin
      cmd.addr = frame_addr_byte;
      cmd.word = frame_word;
      unique case (frame_tag_byte) inside
        mjtm_pkg::REG_ERR_COUNT: begin
          cmd.op   = mjtm_pkg::OP_REG;
          cmd.kind = '0;
        end
        [mjtm_pkg::REG_DOMAIN0:mjtm_pkg::REG_TOTAL]: begin
          cmd.op   = mjtm_pkg::OP_REG;
          cmd.kind = 3'(frame_tag_byte - mjtm_pkg::REG_DOMAIN0) + 3'd1;
        end
        default: begin
          cmd.op = mjtm_pkg::OP_UNKNOWN;
        end
      endcase
    end
  end

endmodule

// File: rtl/mjtm_queue.sv
`timescale 1ns / 1ps
module mjtm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  mjtm_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output mjtm_pkg::cmd_t rd_cmd
);

  mjtm_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_cmd   = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// File: rtl/mjtm_back.sv
`timescale 1ns / 1ps
module mjtm_back #(
  parameter int JOB_SLOTS = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  mjtm_pkg::cmd_t                      cmd,
  input  logic [mjtm_pkg::INTERVAL_W-1:0]     interval,
  output logic                                res_valid,
  input  logic                                res_ready,
  output mjtm_pkg::res_t                      res
);

  localparam int SLOT_W     = $clog2(JOB_SLOTS);
  localparam int FOLD_STEPS = (128 + JOB_SLOTS - 1) / JOB_SLOTS;

  mjtm_pkg::back_state_t state;
  mjtm_pkg::back_state_t state_next;

  mjtm_pkg::cmd_t                   cur;
  logic                             slot_ok;
  logic [31:0]                      rd_version;
  logic [31:0]                      version_mem [JOB_SLOTS];
  logic [JOB_SLOTS-1:0]             valid_bits;
  logic [SLOT_W-1:0]                slot;
  logic                             pop;
  logic                             hit;

  // restoring divider: dvd shifts the dividend out and the quotient in
  logic [mjtm_pkg::CHIP_W-1:0]      dvd;
  logic [mjtm_pkg::INTERVAL_W-1:0]  rem;
  logic [2:0]                       cnt;
  logic [mjtm_pkg::INTERVAL_W:0]    trial;
  logic                             q_bit;

  mjtm_pkg::res_t                   res_next;

  // tag folded onto the slot range
  always_comb begin
    logic [7:0] s;
    s = {1'b0, cmd.tag};
    for (int i = 0; i < FOLD_STEPS; i++) begin
      if (s >= 8'(JOB_SLOTS)) begin
        s = s - 8'(JOB_SLOTS);
      end
    end
    slot = s[SLOT_W-1:0];
  end

  assign cmd_ready = (state == mjtm_pkg::S_IDLE) && !res_valid;
  assign pop       = cmd_valid && cmd_ready;
  assign hit       = valid_bits[slot];

  assign trial = {rem, dvd[mjtm_pkg::CHIP_W-1]};
  assign q_bit = (trial >= {1'b0, interval});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mjtm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mjtm_pkg::S_IDLE: begin
        if (pop) begin
          if (cmd.op == mjtm_pkg::OP_REG || (cmd.op == mjtm_pkg::OP_NONCE && hit)) begin
            state_next = mjtm_pkg::S_DIV;
          end else begin
            state_next = mjtm_pkg::S_EMIT;
          end
        end
      end
      mjtm_pkg::S_DIV: begin
        if (cnt == 3'd7) begin
          state_next = mjtm_pkg::S_EMIT;
        end
      end
      mjtm_pkg::S_EMIT: begin
        state_next = mjtm_pkg::S_IDLE;
      end
      default: begin
        state_next = mjtm_pkg::S_IDLE;
      end
    endcase
  end

  // valid bits and job store
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (pop && cmd.op == mjtm_pkg::OP_ISSUE) begin
      valid_bits[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.op == mjtm_pkg::OP_ISSUE) begin
      version_mem[slot] <= cmd.word;
    end
    if (pop) begin
      rd_version <= version_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= cmd;
      slot_ok <= hit;
      dvd     <= cmd.addr;
      rem     <= '0;
      cnt     <= '0;
    end else if (state == mjtm_pkg::S_DIV) begin
      dvd <= {dvd[mjtm_pkg::CHIP_W-2:0], q_bit};
      rem <= q_bit ? mjtm_pkg::INTERVAL_W'(trial - {1'b0, interval})
                   : trial[mjtm_pkg::INTERVAL_W-1:0];
      cnt <= cnt + 3'd1;
    end
  end

  always_comb begin
    res_next = '0;
    case (cur.op)
      mjtm_pkg::OP_ISSUE: begin
        res_next.status = mjtm_pkg::ST_ISSUED;
        res_next.tag    = cur.tag;
      end
      mjtm_pkg::OP_REG: begin
        res_next.status        = mjtm_pkg::ST_REG;
        res_next.chip_index    = dvd;
        res_next.register_kind = cur.kind;
        res_next.data_word     = cur.word;
      end
      mjtm_pkg::OP_NONCE: begin
        res_next.tag = cur.tag;
        if (slot_ok) begin
          res_next.status       = mjtm_pkg::ST_NONCE;
          res_next.chip_index   = dvd;
          res_next.data_word    = cur.word;
          res_next.full_version = rd_version | {3'b000, cur.fver, 13'b0};
        end else begin
          res_next.status = mjtm_pkg::ST_STALE;
        end
      end
      default: begin
        res_next.status = mjtm_pkg::ST_UNKNOWN_REG;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == mjtm_pkg::S_EMIT) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mjtm_pkg::S_EMIT) begin
      res <= res_next;
    end
  end

  a_pop_only_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == mjtm_pkg::S_IDLE) && !res_valid)
    else $error("command taken while back end busy");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == mjtm_pkg::S_EMIT)
    else $error("result raised outside emit");

  a_stale_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == mjtm_pkg::ST_STALE |->
      res.data_word == '0 && res.full_version == '0 && res.chip_index == '0)
    else $error("stale result carries data");

  a_issue_marks_slot: assert property (@(posedge clk) disable iff (rst)
    pop && cmd.op == mjtm_pkg::OP_ISSUE |=> valid_bits[$past(slot)])
    else $error("issued slot not marked valid");

endmodule

// File: tb/tb_mining_job_tag_result_matcher_core.sv
`timescale 1ns / 1ps
module tb_mining_job_tag_result_matcher_core;

  // beat encodings of the item channel
  localparam logic ACT_ISSUE  = 1'b0;
  localparam logic ACT_FRAME  = 1'b1;
  localparam logic RESP_REG   = 1'b0;
  localparam logic RESP_NONCE = 1'b1;

  // register kinds reported for a register read
  localparam logic [mjtm_pkg::KIND_W-1:0] KIND_ERR     = 3'd0;
  localparam logic [mjtm_pkg::KIND_W-1:0] KIND_DOMAIN0 = 3'd1;

  localparam logic [mjtm_pkg::PADDR_W-1:0] INTERVAL_ADDR =
    mjtm_pkg::PADDR_W'(4 * mjtm_pkg::REG_IDX_INTERVAL);

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int FIXED_PHASES    = 7;
  localparam int PHASES          = 9;
  // zero and very large spacing sit among the fixed settings
  localparam logic [mjtm_pkg::INTERVAL_W-1:0] FIXED_INTERVALS [FIXED_PHASES] =
    '{9'd0, 9'd1, 9'd256, 9'd3, 9'd255, 9'd64, mjtm_pkg::INTERVAL_RESET};

  typedef struct {
    logic        action;
    logic [31:0] job_version;
    logic        is_job;
    logic [31:0] word;
    logic [7:0]  addr_byte;
    logic [7:0]  tag_byte;
    logic [15:0] fver;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // item channel
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [31:0] job_version = '0;
  logic        nonce_resp = 1'b0;
  logic [31:0] frame_word = '0;
  logic [7:0]  frame_addr_byte = '0;
  logic [7:0]  frame_tag_byte = '0;
  logic [15:0] frame_version = '0;

  // result channel
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [mjtm_pkg::STATUS_W-1:0] status;
  logic [mjtm_pkg::TAG_W-1:0]    tag;
  logic [mjtm_pkg::CHIP_W-1:0]   chip_index;
  logic [mjtm_pkg::KIND_W-1:0]   register_kind;
  logic [31:0]                   data_word;
  logic [31:0]                   full_version;

  // config port
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [mjtm_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  // shadow of the job store and the chip spacing
  logic [mjtm_pkg::TAG_W-1:0]      job_tag_next = '0;
  logic [127:0]                    slot_live = '0;
  logic [31:0]                     slot_version [128];
  logic [mjtm_pkg::INTERVAL_W-1:0] interval_cfg = mjtm_pkg::INTERVAL_RESET;

  beat_t          item_backlog [$];
  mjtm_pkg::res_t due_results [$];
  int             fail_count = 0;
  int             idle_cycles = 0;

  // driver side burst shaping
  beat_t cur_item;
  int    burst_left = 8;
  int    gap_left = 0;

  // receiver side stall pattern
  int stall_cycle = 0;
  int stall_left = 0;

  always #10 clk = ~clk;

  mining_job_tag_result_matcher_core dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .job_version     (job_version),
    .nonce_resp      (nonce_resp),
    .frame_word      (frame_word),
    .frame_addr_byte (frame_addr_byte),
    .frame_tag_byte  (frame_tag_byte),
    .frame_version   (frame_version),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .tag             (tag),
    .chip_index      (chip_index),
    .register_kind   (register_kind),
    .data_word       (data_word),
    .full_version    (full_version),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // chip number from an address; zero spacing saturates to all ones
  function automatic logic [mjtm_pkg::CHIP_W-1:0] chip_from(logic [7:0] addr);
    if (interval_cfg == '0) return 8'hFF;
    return mjtm_pkg::CHIP_W'({1'b0, addr} / interval_cfg);
  endfunction

  // advances the job store shadow and returns the result the beat causes
  function automatic mjtm_pkg::res_t resolve_beat(beat_t b);
    mjtm_pkg::res_t             r;
    logic [mjtm_pkg::TAG_W-1:0] t;
    r = '0;
    if (b.action == ACT_ISSUE) begin
      // tag steps by 24 and wraps at 128
      job_tag_next = job_tag_next + mjtm_pkg::TAG_STEP;
      slot_version[job_tag_next] = b.job_version;
      slot_live[job_tag_next] = 1'b1;
      r.status = mjtm_pkg::ST_ISSUED;
      r.tag = job_tag_next;
    end else if (b.is_job == RESP_REG) begin
      if (b.tag_byte == mjtm_pkg::REG_ERR_COUNT ||
          (b.tag_byte >= mjtm_pkg::REG_DOMAIN0 && b.tag_byte <= mjtm_pkg::REG_TOTAL)) begin
        r.status = mjtm_pkg::ST_REG;
        r.register_kind = (b.tag_byte == mjtm_pkg::REG_ERR_COUNT) ? KIND_ERR :
          KIND_DOMAIN0 + mjtm_pkg::KIND_W'(b.tag_byte - mjtm_pkg::REG_DOMAIN0);
        r.chip_index = chip_from(b.addr_byte);
        r.data_word = b.word;
      end else begin
        // unknown register: everything but the status stays zero
        r.status = mjtm_pkg::ST_UNKNOWN_REG;
      end
    end else begin
      // job id in the upper nibble, tag is job id times 8
      t = mjtm_pkg::TAG_W'((b.tag_byte & mjtm_pkg::JOB_ID_MASK) >> 1);
      r.tag = t;
      if (!slot_live[t]) begin
        r.status = mjtm_pkg::ST_STALE;
      end else begin
        r.status = mjtm_pkg::ST_NONCE;
        r.chip_index = chip_from(b.word[mjtm_pkg::NONCE_CHIP_LSB +: 8]);
        r.data_word = b.word;
        r.full_version = slot_version[t] | (32'(b.fver) << mjtm_pkg::VERSION_SHIFT);
      end
    end
    return r;
  endfunction

  // every field random, so ignored fields toggle too
  function automatic beat_t noise_beat();
    beat_t b;
    b.action = 1'($urandom_range(0, 1));
    b.job_version = $urandom();
    b.is_job = 1'($urandom_range(0, 1));
    b.word = $urandom();
    b.addr_byte = 8'($urandom());
    b.tag_byte = 8'($urandom());
    b.fver = 16'($urandom());
    return b;
  endfunction

  function automatic beat_t issue_beat(logic [31:0] ver);
    beat_t b;
    b = noise_beat();
    b.action = ACT_ISSUE;
    b.job_version = ver;
    return b;
  endfunction

  function automatic beat_t reg_beat(logic [7:0] reg_addr, logic [7:0] chip_byte,
                                     logic [31:0] value);
    beat_t b;
    b = noise_beat();
    b.action = ACT_FRAME;
    b.is_job = RESP_REG;
    b.tag_byte = reg_addr;
    b.addr_byte = chip_byte;
    b.word = value;
    return b;
  endfunction

  function automatic beat_t nonce_beat(logic [7:0] job_byte, logic [31:0] nonce,
                                       logic [15:0] ver_bits);
    beat_t b;
    b = noise_beat();
    b.action = ACT_FRAME;
    b.is_job = RESP_NONCE;
    b.tag_byte = job_byte;
    b.word = nonce;
    b.fver = ver_bits;
    return b;
  endfunction

  // mix of issues, register reads (mostly known registers) and nonces
  function automatic beat_t random_beat();
    int         sel;
    int         k;
    logic [7:0] reg_addr;
    sel = $urandom_range(0, 99);
    if (sel < 25) return issue_beat($urandom());
    if (sel < 55) begin
      k = $urandom_range(0, 5);
      reg_addr = (k == 0) ? mjtm_pkg::REG_ERR_COUNT : mjtm_pkg::REG_DOMAIN0 + 8'(k - 1);
      if ($urandom_range(0, 4) == 0) reg_addr = 8'($urandom());
      return reg_beat(reg_addr, 8'($urandom()), $urandom());
    end
    return nonce_beat(8'($urandom()), $urandom(), 16'($urandom()));
  endfunction

  // sender: pops the backlog in bursts, holds each beat until taken
  always @(posedge clk) begin : drive_items
    logic next_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        due_results.push_back(resolve_beat(cur_item));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_backlog.size() > 0) begin
          cur_item = item_backlog.pop_front();
          action <= cur_item.action;
          job_version <= cur_item.job_version;
          nonce_resp <= cur_item.is_job;
          frame_word <= cur_item.word;
          frame_addr_byte <= cur_item.addr_byte;
          frame_tag_byte <= cur_item.tag_byte;
          frame_version <= cur_item.fver;
          next_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // a quarter of the bursts run straight into the next one
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // receiver: checks each result beat and stalls in changing patterns
  always @(posedge clk) begin : observe_results
    mjtm_pkg::res_t want;
    logic           ready_next;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result beat with nothing due: status %0d tag %0d", status, tag);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, status);
            fail_count++;
          end
          if (tag !== want.tag) begin
            $error("tag: expected %0d actual %0d", want.tag, tag);
            fail_count++;
          end
          if (chip_index !== want.chip_index) begin
            $error("chip_index: expected %0d actual %0d", want.chip_index, chip_index);
            fail_count++;
          end
          if (register_kind !== want.register_kind) begin
            $error("register_kind: expected %0d actual %0d",
                   want.register_kind, register_kind);
            fail_count++;
          end
          if (data_word !== want.data_word) begin
            $error("data_word: expected %08h actual %08h", want.data_word, data_word);
            fail_count++;
          end
          if (full_version !== want.full_version) begin
            $error("full_version: expected %08h actual %08h",
                   want.full_version, full_version);
            fail_count++;
          end
        end
      end
      stall_cycle++;
      // pattern picked from bits 9:8 of the cycle counter
      case ((stall_cycle >> 8) % 4)
        0: begin
          ready_next = 1'b1;
        end
        1: begin
          ready_next = ($urandom_range(0, 99) < 70);
        end
        2: begin
          ready_next = (stall_cycle % 5) != 0;
        end
        default: begin
          // occasional long stalls
          if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
          end else begin
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 30);
            ready_next = 1'b1;
          end
        end
      endcase
      out_ready <= ready_next;
    end
  end

  // watchdog on cycles without any handshake or config traffic
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("tb_mining_job_tag_result_matcher_core: FAIL");
        $finish;
      end
    end
  end

  // waits until the backlog is empty, nothing is on the wire and no result is due
  task automatic wait_drained();
    while (item_backlog.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  // apb write of the chip spacing, then read back
  task automatic program_interval(logic [mjtm_pkg::INTERVAL_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= INTERVAL_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    interval_cfg = value;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== 32'(value)) begin
      $error("prdata: expected %0d actual %0d", value, prdata);
      fail_count++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int left;
    int chunk;
    logic [mjtm_pkg::INTERVAL_W-1:0] spacing;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset spacing of 128
    // nonces before any issue hit invalid slots
    item_backlog.push_back(nonce_beat(8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
    item_backlog.push_back(nonce_beat(8'h00, 32'h0000_0000, 16'h0000));
    // every known register, address extremes
    item_backlog.push_back(reg_beat(mjtm_pkg::REG_ERR_COUNT, 8'hFF, 32'hFFFF_FFFF));
    item_backlog.push_back(reg_beat(mjtm_pkg::REG_DOMAIN0, 8'h00, 32'h0000_0000));
    item_backlog.push_back(reg_beat(mjtm_pkg::REG_DOMAIN0 + 8'd1, 8'h7F, 32'h1234_5678));
    item_backlog.push_back(reg_beat(mjtm_pkg::REG_DOMAIN0 + 8'd2, 8'h80, 32'h8000_0001));
    item_backlog.push_back(reg_beat(mjtm_pkg::REG_DOMAIN0 + 8'd3, 8'hAA, 32'hA5A5_5A5A));
    item_backlog.push_back(reg_beat(mjtm_pkg::REG_TOTAL, 8'h55, 32'h5A5A_A5A5));
    // registers just outside the table
    item_backlog.push_back(reg_beat(8'h00, 8'hFF, 32'hFFFF_FFFF));
    item_backlog.push_back(reg_beat(8'hFF, 8'h80, 32'h0F0F_0F0F));
    item_backlog.push_back(reg_beat(mjtm_pkg::REG_DOMAIN0 - 8'd1, 8'h01, 32'h1));
    item_backlog.push_back(reg_beat(mjtm_pkg::REG_TOTAL + 8'd1, 8'hFE, 32'h2));
    item_backlog.push_back(reg_beat(mjtm_pkg::REG_ERR_COUNT + 8'd1, 8'h40, 32'h3));
    // issues and matching nonces, version extremes
    item_backlog.push_back(issue_beat(32'h0000_0000));
    item_backlog.push_back(issue_beat(32'hFFFF_FFFF));
    item_backlog.push_back(nonce_beat(8'h30, 32'h0000_0000, 16'hFFFF));
    item_backlog.push_back(nonce_beat(8'h6F, 32'hFFFF_FFFF, 16'h0000));
    item_backlog.push_back(issue_beat(32'hA5A5_A5A5));
    item_backlog.push_back(nonce_beat(8'h9C, 32'h01FE_0000, 16'h5A5A));
    // tag not issued yet
    item_backlog.push_back(nonce_beat(8'h20, 32'hDEAD_BEEF, 16'h1234));
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      // let the back end settle before touching the spacing
      repeat (12) @(posedge clk);
      spacing = (phase < FIXED_PHASES) ? FIXED_INTERVALS[phase] :
                mjtm_pkg::INTERVAL_W'($urandom_range(1, 256));
      program_interval(spacing);
      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        chunk = $urandom_range(16, 96);
        if (chunk > left) chunk = left;
        repeat (chunk) item_backlog.push_back(random_beat());
        left -= chunk;
        while (item_backlog.size() != 0) @(negedge clk);
        // sender sometimes holds off until all results are back
        if (phase == 0 || $urandom_range(0, 3) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (24) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("results still due at end: %0d", due_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_mining_job_tag_result_matcher_core: PASS");
    end else begin
      $display("tb_mining_job_tag_result_matcher_core: FAIL");
    end
    $finish;
  end

endmodule
